FILE: rtl/core/kvlp_pkg.sv
// kvlp_pkg: shared types and constants of the key/value line parser
// holds result kinds, character codes and the controller/datapath interface structs
// no dependencies
`default_nettype none

package kvlp_pkg;

	localparam int PENDING_MAX_DEF = 16;
	localparam int MAX_RESULTS     = 19;
	localparam int RES_CW          = $clog2(MAX_RESULTS + 1);
	localparam int LINE_W          = 16;

	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] SEP_RESET = 8'd58;

	typedef enum logic [2:0] {
		KIND_KEY      = 3'd0,
		KIND_VALUE    = 3'd1,
		KIND_PAIR_END = 3'd2,
		KIND_NO_VALUE = 3'd3,
		KIND_OVERFLOW = 3'd4,
		KIND_END      = 3'd5
	} kind_t;

	// where the output byte comes from
	typedef enum logic [1:0] {
		BSEL_ZERO = 2'd0,
		BSEL_IN   = 2'd1,
		BSEL_ESC  = 2'd2,
		BSEL_PEND = 2'd3
	} bsel_t;

	typedef struct packed {
		logic  take;       // load the input beat
		logic  emit;       // load the output register
		kind_t kind;
		bsel_t bsel;
		logic  line_new;   // result carries the line after this byte
		logic  last;
		logic  flush_inc;
		logic  flush_clr;
		logic  complete;   // item done, apply state updates
		logic  line_inc;
		logic  pend_clr;
		logic  pend_wr;
		logic  pend_ovf;   // pending store restarts at entry zero
		logic  end_reset;
	} cmd_t;

	typedef struct packed {
		logic is_nl;
		logic is_white;
		logic is_sep;
		logic is_bslash;
		logic last;
		logic pend_full;
		logic pend_empty;
		logic flush_last;
		logic slot_free;
	} sts_t;

endpackage

`default_nettype wire

FILE: rtl/core/kvlp_dpath.sv
// kvlp_dpath: datapath of the key/value line parser
// input and output registers, separator, line counter, pending whitespace memory
// depends on kvlp_pkg
`default_nettype none

module kvlp_dpath
	import kvlp_pkg::*;
#(
	parameter int PENDING_MAX = PENDING_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [7:0]        text_byte,
	input  wire logic              end_of_text,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        separator,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             kind,
	output logic [7:0]             out_byte,
	output logic [LINE_W-1:0]      line_number,
	output logic                   last_of_run,
	input  wire cmd_t              cmd,
	output sts_t                   sts
);

	localparam int AW = (PENDING_MAX > 1) ? $clog2(PENDING_MAX) : 1;
	localparam int CW = $clog2(PENDING_MAX + 1);

	logic [7:0]        sep_q;
	logic [7:0]        byte_q;
	logic              last_q;
	logic [LINE_W-1:0] line_q;
	logic [LINE_W-1:0] line_nx;
	logic [CW-1:0]     pend_cnt_q;
	logic [AW-1:0]     flush_idx_q;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     wr_addr;
	logic [7:0]        rdata_q;
	logic [7:0]        pend_mem [PENDING_MAX];
	logic [7:0]        esc_byte;
	logic [7:0]        sel_byte;
	logic              out_valid_q;
	kind_t             kind_q;
	logic [7:0]        out_byte_q;
	logic [LINE_W-1:0] out_line_q;
	logic              out_last_q;
	logic              pend_we;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sep_q <= SEP_RESET;
		end else if (cfg_valid) begin
			sep_q <= separator;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take) begin
			byte_q <= text_byte;
			last_q <= end_of_text;
		end
	end

	// status of the held byte
	always_comb begin
		sts.is_nl      = (byte_q == CH_NL);
		sts.is_white   = (byte_q == CH_SPACE) || (byte_q == CH_TAB) || (byte_q == CH_NL) ||
		                 (byte_q == CH_CR) || (byte_q == CH_VT) || (byte_q == CH_FF);
		sts.is_sep     = (byte_q == sep_q);
		sts.is_bslash  = (byte_q == CH_BSLASH);
		sts.last       = last_q;
		sts.pend_full  = (pend_cnt_q == CW'(PENDING_MAX));
		sts.pend_empty = (pend_cnt_q == '0);
		sts.flush_last = ((CW'(flush_idx_q) + CW'(1)) == pend_cnt_q);
		sts.slot_free  = !out_valid_q || out_ready;
	end

	// line counter, saturating
	assign line_nx = (cmd.line_inc && (line_q != '1)) ? line_q + LINE_W'(1) : line_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_q <= LINE_W'(1);
		end else if (cmd.complete) begin
			line_q <= cmd.end_reset ? LINE_W'(1) : line_nx;
		end
	end

	// pending whitespace store, write-first registered read
	assign pend_we = cmd.complete && cmd.pend_wr;
	assign wr_addr = cmd.pend_ovf ? '0 : pend_cnt_q[AW-1:0];
	assign rd_addr = cmd.flush_clr ? '0 :
	                 cmd.flush_inc ? flush_idx_q + AW'(1) : flush_idx_q;

	always_ff @(posedge clk) begin
		if (pend_we) begin
			pend_mem[wr_addr] <= byte_q;
		end
		rdata_q <= (pend_we && (wr_addr == rd_addr)) ? byte_q : pend_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_cnt_q  <= '0;
			flush_idx_q <= '0;
		end else begin
			flush_idx_q <= rd_addr;
			if (cmd.complete) begin
				if (cmd.end_reset || cmd.pend_clr) begin
					pend_cnt_q <= '0;
				end else if (cmd.pend_wr) begin
					pend_cnt_q <= cmd.pend_ovf ? CW'(1) : pend_cnt_q + CW'(1);
				end
			end
		end
	end

	assign esc_byte = (byte_q == CH_N) ? CH_NL :
	                  (byte_q == CH_T) ? CH_TAB : byte_q;

	always_comb begin
		unique case (cmd.bsel)
			BSEL_ZERO: sel_byte = 8'h00;
			BSEL_IN:   sel_byte = byte_q;
			BSEL_ESC:  sel_byte = esc_byte;
			BSEL_PEND: sel_byte = rdata_q;
			default:   sel_byte = 8'h00;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			kind_q     <= cmd.kind;
			out_byte_q <= sel_byte;
			out_line_q <= cmd.line_new ? line_nx : line_q;
			out_last_q <= cmd.last;
		end
	end

	assign out_valid   = out_valid_q;
	assign kind        = kind_q;
	assign out_byte    = out_byte_q;
	assign line_number = out_line_q;
	assign last_of_run = out_last_q;

	a_line_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		line_q != '0) else $error("line counter reached zero");

	a_pend_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pend_cnt_q <= CW'(PENDING_MAX)) else $error("pending count above store depth");

	a_emit_lands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |=> out_valid_q) else $error("emitted result not held in output register");

endmodule

`default_nettype wire

FILE: rtl/core/kvlp_ctrl.sv
// kvlp_ctrl: controller of the key/value line parser
// parse mode and per-byte result sequencing: overflow, flush, main, tail, end
// depends on kvlp_pkg
`default_nettype none

module kvlp_ctrl
	import kvlp_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		M_SKIP   = 3'd0,
		M_KEY    = 3'd1,
		M_VALUE  = 3'd2,
		M_ESC    = 3'd3,
		M_IGNORE = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		PH_NEW   = 3'd0,
		PH_OVF   = 3'd1,
		PH_FLUSH = 3'd2,
		PH_MAIN  = 3'd3,
		PH_TAIL  = 3'd4,
		PH_END   = 3'd5,
		PH_DONE  = 3'd6
	} phase_t;

	mode_t            mode_q;
	mode_t            new_mode;
	phase_t           phase_q;
	phase_t           eff;
	phase_t           nxt;
	logic             have_q;
	logic [RES_CW-1:0] cnt_q;
	logic             key_path;
	logic             k_nl;
	logic             k_sep;
	logic             k_white;
	logic             k_other;
	logic             ovf;
	logic             flush_en;
	logic             main_en;
	kind_t            main_kind;
	bsel_t            main_bsel;
	logic             line_inc;
	logic             tail_en;
	logic [4:0]       app;
	logic             suppress;
	logic             step;
	logic             complete;
	logic             take;

	function automatic phase_t next_after(input phase_t p, input logic [4:0] a);
		if (p < PH_OVF && a[0]) return PH_OVF;
		else if (p < PH_FLUSH && a[1]) return PH_FLUSH;
		else if (p < PH_MAIN && a[2]) return PH_MAIN;
		else if (p < PH_TAIL && a[3]) return PH_TAIL;
		else if (p < PH_END && a[4]) return PH_END;
		else return PH_DONE;
	endfunction

	// a non-white byte in skip mode is handled as in key mode
	assign key_path = (mode_q == M_KEY) || ((mode_q == M_SKIP) && !sts.is_white);
	assign k_nl     = key_path && sts.is_nl;
	assign k_sep    = key_path && !sts.is_nl && sts.is_sep;
	assign k_white  = key_path && !sts.is_nl && !sts.is_sep && sts.is_white;
	assign k_other  = key_path && !sts.is_nl && !sts.is_sep && !sts.is_white;
	assign ovf      = k_white && sts.pend_full;
	assign flush_en = (ovf || k_other) && !sts.pend_empty;

	always_comb begin
		main_en   = 1'b0;
		main_kind = KIND_KEY;
		main_bsel = BSEL_ZERO;
		new_mode  = mode_q;
		line_inc  = 1'b0;
		unique case (mode_q)
			M_SKIP, M_KEY: begin
				if (k_nl) begin
					main_en   = 1'b1;
					main_kind = KIND_NO_VALUE;
					new_mode  = M_IGNORE;
				end else if (k_sep) begin
					new_mode = M_VALUE;
				end else if (k_white) begin
					new_mode = M_KEY;
				end else if (k_other) begin
					main_en   = 1'b1;
					main_bsel = BSEL_IN;
					new_mode  = M_KEY;
				end else begin
					line_inc = sts.is_nl;
				end
			end
			M_VALUE: begin
				if (sts.is_nl) begin
					main_en   = 1'b1;
					main_kind = KIND_PAIR_END;
					line_inc  = 1'b1;
					new_mode  = M_SKIP;
				end else if (sts.is_bslash) begin
					new_mode = M_ESC;
				end else begin
					main_en   = 1'b1;
					main_kind = KIND_VALUE;
					main_bsel = BSEL_IN;
				end
			end
			M_ESC: begin
				main_en   = 1'b1;
				main_kind = KIND_VALUE;
				main_bsel = BSEL_ESC;
				line_inc  = sts.is_nl;
				new_mode  = M_VALUE;
			end
			M_IGNORE: begin
				new_mode = M_IGNORE;
			end
			default: begin
				new_mode = M_SKIP;
			end
		endcase
	end

	assign tail_en = sts.last &&
	                 ((new_mode == M_KEY) || (new_mode == M_VALUE) || (new_mode == M_ESC));
	assign app     = {sts.last, tail_en, main_en, flush_en, ovf};

	assign eff      = (phase_q == PH_NEW) ? next_after(PH_NEW, app) : phase_q;
	assign suppress = (cnt_q >= RES_CW'(MAX_RESULTS));
	assign step     = have_q && (eff != PH_DONE) && (suppress || sts.slot_free);
	assign nxt      = ((eff == PH_FLUSH) && !sts.flush_last) ? PH_FLUSH : next_after(eff, app);
	assign complete = have_q && ((eff == PH_DONE) || (step && (nxt == PH_DONE)));
	assign in_ready = !have_q || complete;
	assign take     = in_valid && in_ready;

	always_comb begin
		cmd           = '0;
		cmd.take      = take;
		cmd.emit      = step && !suppress;
		cmd.last      = (nxt == PH_DONE) || (cnt_q == RES_CW'(MAX_RESULTS - 1));
		cmd.flush_inc = step && (eff == PH_FLUSH) && !sts.flush_last;
		cmd.flush_clr = step && (eff == PH_FLUSH) && sts.flush_last;
		cmd.complete  = complete;
		cmd.line_inc  = line_inc;
		cmd.pend_clr  = k_sep || k_other;
		cmd.pend_wr   = k_white;
		cmd.pend_ovf  = ovf;
		cmd.end_reset = sts.last;
		unique case (eff)
			PH_OVF: begin
				cmd.kind = KIND_OVERFLOW;
				cmd.bsel = BSEL_ZERO;
			end
			PH_FLUSH: begin
				cmd.kind = KIND_KEY;
				cmd.bsel = BSEL_PEND;
			end
			PH_MAIN: begin
				cmd.kind = main_kind;
				cmd.bsel = main_bsel;
			end
			PH_TAIL: begin
				cmd.kind     = (new_mode == M_KEY) ? KIND_NO_VALUE : KIND_PAIR_END;
				cmd.bsel     = BSEL_ZERO;
				cmd.line_new = 1'b1;
			end
			PH_END: begin
				cmd.kind     = KIND_END;
				cmd.bsel     = BSEL_ZERO;
				cmd.line_new = 1'b1;
			end
			default: begin
				cmd.kind = KIND_KEY;
				cmd.bsel = BSEL_ZERO;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= M_SKIP;
			phase_q <= PH_NEW;
			have_q  <= 1'b0;
			cnt_q   <= '0;
		end else begin
			if (complete) begin
				mode_q <= sts.last ? M_SKIP : new_mode;
				cnt_q  <= '0;
			end else if (step && !suppress) begin
				cnt_q <= cnt_q + RES_CW'(1);
			end
			if (take) begin
				have_q  <= 1'b1;
				phase_q <= PH_NEW;
			end else if (complete) begin
				have_q <= 1'b0;
			end else if (step) begin
				phase_q <= nxt;
			end
		end
	end

	a_emit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> sts.slot_free) else $error("result emitted into a full output register");

	a_ignore_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(have_q && (mode_q == M_IGNORE) && !sts.last) |-> !cmd.emit)
		else $error("result produced while ignoring rest of text");

	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		(complete && sts.last) |=> (mode_q == M_SKIP))
		else $error("mode not back to skip after end of text");

endmodule

`default_nettype wire

FILE: rtl/core/key_value_line_parser.sv
// key_value_line_parser: top level, joins controller and datapath
// depends on kvlp_pkg, kvlp_ctrl, kvlp_dpath
//
// Usage:
//  - text enters one byte per beat on in_valid/in_ready with text_byte and
//    end_of_text; results leave on out_valid/out_ready as kind, out_byte,
//    line_number and last_of_run (set on the final result of a byte)
//  - the user must write the separator on cfg_valid/cfg_ready only while the
//    block is idle, which the block does not enforce; cfg_ready is always high
//  - a byte accepted is held in the input register, and its first result is
//    registered in the output register once the output slot is free
//  - throughput: the results of a byte are loaded in turn, and a byte with no
//    result completes in the cycle in which it is held, so a text that gives
//    at most one result per byte flows at one byte per cycle while the receiver
//    is ready; a flush of held key whitespace gives one result per held byte
//    (up to PENDING_MAX), read through the single read port of the pending memory
//  - a stalled receiver holds the result in the output register and the
//    sequencer waits; the next byte is taken as soon as the current byte's
//    last result is loaded
//  - reset: separator ':' (58), skip mode, line one, no pending whitespace;
//    no clearing pass is needed
`default_nettype none

module key_value_line_parser
	import kvlp_pkg::*;
#(
	parameter int PENDING_MAX = PENDING_MAX_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [7:0]        text_byte,
	input  wire logic              end_of_text,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic [7:0]        separator,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic [2:0]             kind,
	output logic [7:0]             out_byte,
	output logic [LINE_W-1:0]      line_number,
	output logic                   last_of_run
);

	cmd_t cmd;
	sts_t sts;

	kvlp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	kvlp_dpath #(
		.PENDING_MAX (PENDING_MAX)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.separator   (separator),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind        (kind),
		.out_byte    (out_byte),
		.line_number (line_number),
		.last_of_run (last_of_run),
		.cmd         (cmd),
		.sts         (sts)
	);

endmodule

`default_nettype wire
